[rtl/hop_channel_table_generator_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef HOP_CHANNEL_TABLE_GENERATOR_CORE_DEFINES_SVH
`define HOP_CHANNEL_TABLE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HCTG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HCTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hctg_pkg.sv]
package hctg_pkg;

  localparam int unsigned TABLE_LEN = 21;

  localparam int unsigned SEED_W = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned BCNT_W = 4;

  localparam logic [31:0] LCG_MUL = 32'h0019_660D;
  localparam logic [31:0] LCG_ADD = 32'h3C6E_F35F;

  // Candidate source is state[31:8]; remainder by 141 via reciprocal.
  localparam int unsigned X_W     = 24;
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned QUOT_W  = 17;
  localparam logic [RECIP_W-1:0] CHAN_RECIP = 25'd30460761; // ceil(2^32/141)
  localparam logic [7:0]         CHAN_MOD   = 8'd141;

  // Even channels 0..140 map to 71 presence bits.
  localparam int unsigned NUM_EVEN = 71;
  localparam int unsigned EIDX_W   = 7;

  localparam logic [CHAN_W-1:0] BAND0_TOP = 8'd47;
  localparam logic [CHAN_W-1:0] BAND1_TOP = 8'd93;
  localparam logic [BCNT_W-1:0] BAND_CAP  = 4'd8;
  localparam int unsigned       NUM_BANDS = 3;
  localparam int unsigned       BAND_W    = 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_LEN - 1);

  typedef struct packed {
    logic load;
    logic step;
    logic div;
    logic rem;
    logic check;
  } hctg_cmd_t;

  typedef struct packed {
    logic accept;
    logic done;
  } hctg_stat_t;

endpackage

[rtl/hctg_ctrl.sv]
module hctg_ctrl
  import hctg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  hctg_stat_t stat,
  output hctg_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_DIV,
    S_REM,
    S_CHECK
  } state_t;

  state_t state;

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == S_IDLE) && start;
    cmd.step  = (state == S_STEP);
    cmd.div   = (state == S_DIV);
    cmd.rem   = (state == S_REM);
    cmd.check = (state == S_CHECK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_STEP;
            busy  <= 1'b1;
          end
        end
        S_STEP:  state <= S_DIV;
        S_DIV:   state <= S_REM;
        S_REM:   state <= S_CHECK;
        S_CHECK: begin
          // drop back to idle once the final slot is filled
          if (stat.done) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end else begin
            state <= S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/hctg_datapath.sv]
module hctg_datapath
  import hctg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  hctg_cmd_t         cmd,
  input  logic [SEED_W-1:0] seed,
  output hctg_stat_t        stat,
  output logic              valid,
  output logic [CHAN_W-1:0] channel,
  output logic [SLOT_W-1:0] slot,
  output logic              last
);

  logic [SEED_W-1:0]  gen;
  logic [QUOT_W-1:0]  quot;
  logic [CHAN_W-1:0]  cand;
  logic [SLOT_W-1:0]  fill;
  logic [NUM_EVEN-1:0] seen;
  logic [BCNT_W-1:0]  band_cnt [NUM_BANDS];

  logic [X_W-1:0]             x;
  logic [X_W+RECIP_W-1:0]     prod;
  logic [X_W-1:0]             qm;
  logic [X_W-1:0]             rem;
  logic [EIDX_W-1:0]          eidx;
  logic [BAND_W-1:0]          band;
  logic                       accept;

  assign x    = gen[SEED_W-1:8];
  assign prod = (X_W+RECIP_W)'(x) * (X_W+RECIP_W)'(CHAN_RECIP);
  assign qm   = X_W'(quot) * X_W'(CHAN_MOD);
  assign rem  = x - qm;
  assign eidx = cand[CHAN_W-1:1];

  always_comb begin
    if (cand <= BAND0_TOP) begin
      band = 2'd0;
    end else if (cand <= BAND1_TOP) begin
      band = 2'd1;
    end else begin
      band = 2'd2;
    end
  end

  assign accept      = !seen[eidx] && (band_cnt[band] < BAND_CAP);
  assign stat.accept = cmd.check && accept;
  assign stat.done   = cmd.check && accept && (fill == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      fill  <= '0;
      seen  <= '0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_cnt[i] <= '0;
      end
    end else begin
      valid <= 1'b0;
      if (cmd.load) begin
        fill <= '0;
        seen <= '0;
        for (int i = 0; i < NUM_BANDS; i++) begin
          band_cnt[i] <= '0;
        end
      end else if (stat.accept) begin
        valid          <= 1'b1;
        fill           <= fill + 1'b1;
        seen[eidx]     <= 1'b1;
        band_cnt[band] <= band_cnt[band] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gen <= seed;
    end else if (cmd.step) begin
      gen <= gen * LCG_MUL + LCG_ADD;
    end
    if (cmd.div) begin
      quot <= prod[X_W+RECIP_W-1:32];
    end
    if (cmd.rem) begin
      cand <= {rem[CHAN_W-1:1], 1'b0};
    end
    if (stat.accept) begin
      channel <= cand;
      slot    <= fill;
      last    <= (fill == LAST_SLOT);
    end
  end

endmodule

[rtl/hop_channel_table_generator_core.sv]
// Hop channel table generator. Pulse start with a 32-bit seed while busy is
// low; the item is taken at that edge and busy rises in the next cycle. The
// block steps a 32-bit LCG from the seed and emits TABLE_LEN distinct even
// channels (0..140), at most 8 per band, each as a one-cycle valid pulse
// with channel, slot (0 first) and last on the final slot. Results are
// never held: the receiver must take every valid cycle, it cannot stall.
// Every generator draw runs through the sequencer states for LCG multiply,
// reciprocal multiply for mod 141, remainder and table check, so busy stays
// high until TABLE_LEN candidates are accepted: one draw per slot at least,
// and more for each rejected candidate. The last result shows in the cycle
// busy is low again, so a new start may follow at once.
module hop_channel_table_generator_core
  import hctg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [SEED_W-1:0] seed,
  output logic              valid,
  output logic [CHAN_W-1:0] channel,
  output logic [SLOT_W-1:0] slot,
  output logic              last
);

  hctg_cmd_t  cmd;   // sequencer commands into the datapath
  hctg_stat_t stat;  // candidate verdict back to the sequencer

  // Sequence the four draw phases and hold busy until the table is full.
  hctg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Generator, mod-141 reduction, duplicate bitmap and band counters.
  hctg_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .seed    (seed),
    .stat    (stat),
    .valid   (valid),
    .channel (channel),
    .slot    (slot),
    .last    (last)
  );

endmodule

[rtl/hctg_checker.sv]
`include "hop_channel_table_generator_core_defines.svh"

module hctg_checker
  import hctg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [SEED_W-1:0] seed,
  input logic              valid,
  input logic [CHAN_W-1:0] channel,
  input logic [SLOT_W-1:0] slot,
  input logic              last
);

  logic [CHAN_W-1:0] seed_low;
  assign seed_low = seed[CHAN_W-1:0];

  `HCTG_ASSERT_NOW(a_chan_even, clk, rst, valid, (channel <= 8'd140) && !channel[0], "channel out of range or odd")
  `HCTG_ASSERT_NOW(a_last_slot, clk, rst, valid, (last == (slot == LAST_SLOT)) && (slot <= LAST_SLOT), "last flag does not match slot")
  `HCTG_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy, "accepted item did not raise busy")
  `HCTG_ASSERT_NOW(a_mid_busy, clk, rst, valid && !last, busy, "mid-table result while idle")
  `HCTG_ASSERT_NEXT(a_end_idle, clk, rst, valid && last && (seed_low == seed_low), !valid || (slot == '0), "result after final slot")

endmodule

bind hop_channel_table_generator_core hctg_checker u_hctg_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .seed    (seed),
  .valid   (valid),
  .channel (channel),
  .slot    (slot),
  .last    (last)
);
